// File: rtl/core/shgg_pkg.sv
// Shared types and constants of the stepped horizontal gradient generator.
`timescale 1ns / 1ps

package shgg_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int FRACTION_BITS = 16;

   localparam int DIM_W     = $clog2(MAX_WIDTH + 1);
   localparam int CHAN_W    = 8;
   localparam int COLOR_W   = 3 * CHAN_W;
   localparam int ACC_W     = FRACTION_BITS + CHAN_W;
   localparam int INC_W     = ACC_W + 1;
   localparam int DIV_W     = ACC_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_COLOR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COLOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd4;

   localparam logic [COLOR_W-1:0] START_COLOR_RST  = 24'h000000;
   localparam logic [COLOR_W-1:0] END_COLOR_RST    = 24'hFFFFFF;
   localparam logic [DIM_W-1:0]   STEP_COUNT_RST   = 13'd100;
   localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 13'd400;
   localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 13'd130;

   // request to the shared divider; start may come at any time and restarts it
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // channel k: 0 red, 1 green, 2 blue
   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                 input logic [1:0] k);
      logic [CHAN_W-1:0] res;
      unique case (k)
         2'd0:    res = color[23:16];
         2'd1:    res = color[15:8];
         default: res = color[7:0];
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/shgg_div.sv
// Restoring divider, one quotient bit per cycle, shared by the setup sequencer.
`timescale 1ns / 1ps

module shgg_div (
   input  logic                      clock,
   input  logic                      reset,
   input  shgg_pkg::div_req_type     req,
   output shgg_pkg::div_rsp_type     rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [shgg_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [shgg_pkg::DIM_W-1:0]          rem_ff, rem_in;
   logic [shgg_pkg::DIM_W-1:0]          dsr_ff, dsr_in;
   logic [shgg_pkg::DIV_W-1:0]          quo_ff, quo_in;
   logic [shgg_pkg::DIM_W:0]            trial;
   logic                                ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[shgg_pkg::DIV_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = shgg_pkg::DIV_CNT_W'(shgg_pkg::DIV_W - 1);
         rem_in  = '0;
         dsr_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in = ge ? shgg_pkg::DIM_W'(trial - {1'b0, dsr_ff})
                     : trial[shgg_pkg::DIM_W-1:0];
         quo_in = {quo_ff[shgg_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: rtl/core/stepped_horizontal_gradient_generator.sv
// Top level: config registers, setup sequencer and the per-pixel scan.
// A pixel word appears on rsp in the cycle after its req word is accepted.
// Throughput: one word per cycle while req_stall is low, set by the single registered pass of the scan logic.
// After reset or a config write the divider runs five divisions (band width, step count,
// three increments), or only the first two for a solid row; req_stall stays high meanwhile.
// Reset restores default registers.
`timescale 1ns / 1ps

module stepped_horizontal_gradient_generator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [shgg_pkg::CHAN_W-1:0]      rsp_red,
   output logic [shgg_pkg::CHAN_W-1:0]      rsp_green,
   output logic [shgg_pkg::CHAN_W-1:0]      rsp_blue,
   output logic                             rsp_row_end,
   output logic                             rsp_frame_end,
   input  logic                             csr_we,
   input  logic [shgg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shgg_pkg::COLOR_W-1:0]     csr_data
);

   localparam logic [2:0] SEQ_IDLE    = 3'd0;
   localparam logic [2:0] SEQ_BW_GO   = 3'd1;
   localparam logic [2:0] SEQ_BW_WAIT = 3'd2;
   localparam logic [2:0] SEQ_D_GO    = 3'd3;
   localparam logic [2:0] SEQ_D_WAIT  = 3'd4;
   localparam logic [2:0] SEQ_CH_GO   = 3'd5;
   localparam logic [2:0] SEQ_CH_WAIT = 3'd6;

   // config registers
   logic [shgg_pkg::COLOR_W-1:0] start_ff, end_ff;
   logic [shgg_pkg::DIM_W-1:0]   step_ff, width_ff, height_ff;
   logic                         cfg_hit;

   // derived values
   logic [2:0]                   seq_ff, seq_in;
   logic [1:0]                   ch_ff, ch_in;
   logic [shgg_pkg::DIM_W-1:0]   bw_ff, bw_in;
   logic [shgg_pkg::DIM_W-1:0]   d_ff, d_in;
   logic [shgg_pkg::INC_W-1:0]   inc_ff [3];
   logic [shgg_pkg::INC_W-1:0]   inc_in [3];
   logic [shgg_pkg::DIM_W-1:0]   eff_w, eff_h, steps;
   logic [shgg_pkg::CHAN_W:0]    diff;
   logic [shgg_pkg::CHAN_W-1:0]  mag;
   logic [shgg_pkg::INC_W-1:0]   quo_ext;
   shgg_pkg::div_req_type        div_req;
   shgg_pkg::div_rsp_type        div_rsp;

   // scan state
   logic                         pend_ff;
   logic [shgg_pkg::DIM_W-1:0]   col_ff, col_in, row_ff, row_in, band_ff, band_in;
   logic [shgg_pkg::ACC_W-1:0]   acc_ff [3];
   logic [shgg_pkg::ACC_W-1:0]   acc_in [3];
   logic [shgg_pkg::ACC_W-1:0]   acc_start [3];
   logic [shgg_pkg::ACC_W-1:0]   acc_e [3];
   logic [shgg_pkg::ACC_W-1:0]   acc_n [3];
   logic [shgg_pkg::DIM_W-1:0]   col_e, row_e, band_e, band_nx, row_nx;
   logic                         restart_e, step_now, last_col, last_row, req_acc;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [shgg_pkg::CHAN_W-1:0]  red_ff, green_ff, blue_ff;
   logic                         row_end_ff, frame_end_ff;

   always_comb begin
      unique case (csr_index)
         shgg_pkg::CSR_START_COLOR, shgg_pkg::CSR_END_COLOR, shgg_pkg::CSR_STEP_COUNT,
         shgg_pkg::CSR_FRAME_WIDTH, shgg_pkg::CSR_FRAME_HEIGHT: cfg_hit = csr_we;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= shgg_pkg::START_COLOR_RST;
         end_ff    <= shgg_pkg::END_COLOR_RST;
         step_ff   <= shgg_pkg::STEP_COUNT_RST;
         width_ff  <= shgg_pkg::FRAME_WIDTH_RST;
         height_ff <= shgg_pkg::FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            shgg_pkg::CSR_START_COLOR:  start_ff  <= csr_data;
            shgg_pkg::CSR_END_COLOR:    end_ff    <= csr_data;
            shgg_pkg::CSR_STEP_COUNT:   step_ff   <= csr_data[shgg_pkg::DIM_W-1:0];
            shgg_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data[shgg_pkg::DIM_W-1:0];
            shgg_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data[shgg_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   always_comb begin
      priority if (width_ff == '0)
         eff_w = shgg_pkg::DIM_W'(1);
      else if (width_ff > shgg_pkg::DIM_W'(shgg_pkg::MAX_WIDTH))
         eff_w = shgg_pkg::DIM_W'(shgg_pkg::MAX_WIDTH);
      else
         eff_w = width_ff;
      priority if (height_ff == '0)
         eff_h = shgg_pkg::DIM_W'(1);
      else if (height_ff > shgg_pkg::DIM_W'(shgg_pkg::MAX_HEIGHT))
         eff_h = shgg_pkg::DIM_W'(shgg_pkg::MAX_HEIGHT);
      else
         eff_h = height_ff;
      steps = (step_ff > eff_w) ? eff_w : step_ff;
   end

   // setup sequencer: band width, step count, then one increment per channel
   always_comb begin
      seq_in  = seq_ff;
      ch_in   = ch_ff;
      bw_in   = bw_ff;
      d_in    = d_ff;
      for (int k = 0; k < 3; k++) inc_in[k] = inc_ff[k];
      diff    = {1'b0, shgg_pkg::chan_of(end_ff, ch_ff)}
              - {1'b0, shgg_pkg::chan_of(start_ff, ch_ff)};
      mag     = diff[shgg_pkg::CHAN_W] ? shgg_pkg::CHAN_W'(-diff)
                                       : diff[shgg_pkg::CHAN_W-1:0];
      quo_ext = {1'b0, div_rsp.quotient};
      div_req.start    = 1'b0;
      div_req.dividend = {{(shgg_pkg::DIV_W - shgg_pkg::DIM_W){1'b0}}, eff_w};
      div_req.divisor  = steps + 1'b1;
      unique case (seq_ff)
         SEQ_IDLE: ;
         SEQ_BW_GO: begin
            div_req.start = 1'b1;
            seq_in        = SEQ_BW_WAIT;
         end
         SEQ_BW_WAIT: begin
            if (div_rsp.done) begin
               bw_in  = (div_rsp.quotient == '0) ? shgg_pkg::DIM_W'(1)
                                                 : div_rsp.quotient[shgg_pkg::DIM_W-1:0];
               seq_in = SEQ_D_GO;
            end
         end
         SEQ_D_GO: begin
            div_req.divisor = bw_ff;
            div_req.start   = 1'b1;
            seq_in          = SEQ_D_WAIT;
         end
         SEQ_D_WAIT: begin
            if (div_rsp.done) begin
               d_in = div_rsp.quotient[shgg_pkg::DIM_W-1:0] - 1'b1;
               ch_in = 2'd0;
               if (div_rsp.quotient[shgg_pkg::DIM_W-1:0] == shgg_pkg::DIM_W'(1)) begin
                  // one band only: solid start color
                  for (int k = 0; k < 3; k++) inc_in[k] = '0;
                  seq_in = SEQ_IDLE;
               end else begin
                  seq_in = SEQ_CH_GO;
               end
            end
         end
         SEQ_CH_GO: begin
            div_req.dividend = {mag, {shgg_pkg::FRACTION_BITS{1'b0}}};
            div_req.divisor  = d_ff;
            div_req.start    = 1'b1;
            seq_in           = SEQ_CH_WAIT;
         end
         SEQ_CH_WAIT: begin
            if (div_rsp.done) begin
               // truncate toward zero: divide magnitude, then restore sign
               inc_in[ch_ff] = diff[shgg_pkg::CHAN_W] ? -quo_ext : quo_ext;
               if (ch_ff == 2'd2) begin
                  seq_in = SEQ_IDLE;
               end else begin
                  ch_in  = ch_ff + 1'b1;
                  seq_in = SEQ_CH_GO;
               end
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
      if (cfg_hit) seq_in = SEQ_BW_GO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_BW_GO;
         ch_ff  <= 2'd0;
      end else begin
         seq_ff <= seq_in;
         ch_ff  <= ch_in;
      end
      bw_ff <= bw_in;
      d_ff  <= d_in;
      for (int k = 0; k < 3; k++) inc_ff[k] <= inc_in[k];
   end

   shgg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // handshake: the result register frees up in the cycle it is taken
   assign req_stall = (seq_ff != SEQ_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;

   // pixel pass
   always_comb begin
      restart_e = req_restart || pend_ff;
      col_e     = restart_e ? shgg_pkg::DIM_W'(1) : col_ff;
      row_e     = restart_e ? '0 : row_ff;
      band_e    = restart_e ? '0 : band_ff;
      step_now  = (band_e == bw_ff - 1'b1) && ((eff_w - col_e) >= bw_ff);
      for (int k = 0; k < 3; k++) begin
         acc_start[k] = {shgg_pkg::chan_of(start_ff, 2'(k)), {shgg_pkg::FRACTION_BITS{1'b0}}};
         acc_e[k]     = restart_e ? acc_start[k] : acc_ff[k];
         // the running sum never leaves the start..end range, so no wrap or clamp
         acc_n[k]     = step_now ? shgg_pkg::ACC_W'({1'b0, acc_e[k]} + inc_ff[k]) : acc_e[k];
      end
      last_col = col_e >= eff_w;
      row_nx   = row_e + 1'b1;
      last_row = row_nx >= eff_h;
      band_nx  = band_e + 1'b1;
      if (last_col) begin
         col_in  = shgg_pkg::DIM_W'(1);
         band_in = '0;
         row_in  = last_row ? '0 : row_nx;
         for (int k = 0; k < 3; k++) acc_in[k] = acc_start[k];
      end else begin
         col_in  = col_e + 1'b1;
         band_in = (band_nx >= bw_ff) ? '0 : band_nx;
         row_in  = row_e;
         for (int k = 0; k < 3; k++) acc_in[k] = acc_n[k];
      end
   end

   always_comb begin
      if (req_acc)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b1;
         col_ff       <= shgg_pkg::DIM_W'(1);
         row_ff       <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_hit) begin
            pend_ff <= 1'b1;
         end else if (req_acc) begin
            pend_ff <= 1'b0;
            col_ff  <= col_in;
            row_ff  <= row_in;
            band_ff <= band_in;
         end
      end
      if (req_acc) begin
         for (int k = 0; k < 3; k++) acc_ff[k] <= acc_in[k];
         red_ff       <= acc_n[0][shgg_pkg::ACC_W-1:shgg_pkg::FRACTION_BITS];
         green_ff     <= acc_n[1][shgg_pkg::ACC_W-1:shgg_pkg::FRACTION_BITS];
         blue_ff      <= acc_n[2][shgg_pkg::ACC_W-1:shgg_pkg::FRACTION_BITS];
         row_end_ff   <= last_col;
         frame_end_ff <= last_col && last_row;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

`ifndef SYNTHESIS
   // scan position stays inside the row once setup is done
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_IDLE && !pend_ff && !cfg_hit) |-> (col_ff != '0 && col_ff <= eff_w))
      else $error("column count outside row");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_IDLE && !pend_ff && !cfg_hit) |-> (band_ff < bw_ff))
      else $error("band count not below band width");

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid)
      else $error("accepted word gave no result");
`endif

endmodule
